// ----- design/e2q_pkg.sv -----
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants
// Fixed-point formats and CORDIC arctangent table for Euler to quaternion.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_W  = 16;
  localparam int QUAT_W   = 16;
  localparam int CW       = 34;   // Q2.30 plus guard bits
  localparam int ATAN_LEN = 24;

  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef logic signed [CW-1:0] cval_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
  } quat_t;

  function automatic cval_t atan_q30(input int i);
    cval_t r;
    case (i)
      0: r = 34'sd843314856;   1: r = 34'sd497837829;
      2: r = 34'sd263043836;   3: r = 34'sd133525158;
      4: r = 34'sd67021686;    5: r = 34'sd33543515;
      6: r = 34'sd16775850;    7: r = 34'sd8388437;
      8: r = 34'sd4194282;     9: r = 34'sd2097149;
      10: r = 34'sd1048575;    11: r = 34'sd524287;
      12: r = 34'sd262143;     13: r = 34'sd131071;
      14: r = 34'sd65535;      15: r = 34'sd32767;
      16: r = 34'sd16383;      17: r = 34'sd8191;
      18: r = 34'sd4095;       19: r = 34'sd2047;
      20: r = 34'sd1023;       21: r = 34'sd511;
      22: r = 34'sd255;        23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/e2q_stream_if.sv -----
// ----------------------------------------------------------------------------
// e2q_stream_if: valid/ready channel
// Carries one payload item per handshake.
// ----------------------------------------------------------------------------
interface e2q_stream_if #(parameter int W = 48);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/e2q_cordic.sv -----
// ----------------------------------------------------------------------------
// e2q_cordic: pipelined half-angle sine/cosine
// One range-reduction stage then one register stage per CORDIC iteration.
// ----------------------------------------------------------------------------
module e2q_cordic #(
  parameter int STEPS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] angle,
  output e2q_pkg::cval_t                sin_o,
  output e2q_pkg::cval_t                cos_o
);
  import e2q_pkg::*;

  localparam int N = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;

  cval_t x_r [N+1];
  cval_t y_r [N+1];
  cval_t z_r [N+1];
  logic  neg_r [N+1];
  cval_t z0;

  always_comb begin
    z0 = {{(CW-ANGLE_W-16){angle[ANGLE_W-1]}}, angle, 16'd0};
  end

  // range reduction into [-pi/2, pi/2]
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      if (z0 > HALF_PI_Q30) begin
        z_r[0] <= PI_Q30 - z0;
        neg_r[0] <= 1'b1;
      end else if (z0 < -HALF_PI_Q30) begin
        z_r[0] <= -PI_Q30 - z0;
        neg_r[0] <= 1'b1;
      end else begin
        z_r[0] <= z0;
        neg_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q30(i);
        end
      end
    end
  end

  assign sin_o = y_r[N];
  assign cos_o = neg_r[N] ? -x_r[N] : x_r[N];
endmodule

// ----- design/e2q_combine.sv -----
// ----------------------------------------------------------------------------
// e2q_combine: triple products, sum, round and saturate
// Three register stages: pair products, triple products, rounded result.
// ----------------------------------------------------------------------------
module e2q_combine #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic           clk,
  input  logic           en,
  input  e2q_pkg::cval_t sr, cr, sp, cp, sy, cy,
  output e2q_pkg::quat_t quat
);
  import e2q_pkg::*;

  localparam int PW  = 2 * CW;
  localparam int TW  = PW + CW;
  localparam int SH  = 60 - OUT_FRAC_BITS;
  localparam int LIM = ((1 << OUT_FRAC_BITS) > 32767) ? 32767 : (1 << OUT_FRAC_BITS);
  localparam logic signed [TW-1:0] HALF = TW'(1) <<< (SH - 1);
  localparam logic signed [TW-1:0] LIMV = TW'(LIM);

  // pair products floored to Q30: cc, sc, cs, ss of roll/pitch
  cval_t cc_r, ss_r, sc_r, cs_r, sy_r, cy_r;
  logic signed [PW-1:0] p_cc, p_ss, p_sc, p_cs;
  logic signed [TW-1:0] t_r [8];
  logic signed [TW-1:0] s [4];
  logic signed [TW-1:0] v [4];
  logic signed [QUAT_W-1:0] q [4];
  quat_t quat_r;

  assign p_cc = cr * cp;
  assign p_ss = sr * sp;
  assign p_sc = sr * cp;
  assign p_cs = cr * sp;

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r <= CW'(p_cc >>> 30);
      ss_r <= CW'(p_ss >>> 30);
      sc_r <= CW'(p_sc >>> 30);
      cs_r <= CW'(p_cs >>> 30);
      sy_r <= sy;
      cy_r <= cy;
    end
  end

  // widen both factors so the full Q60 product is kept
  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= TW'(cc_r) * TW'(cy_r);
      t_r[1] <= TW'(ss_r) * TW'(sy_r);
      t_r[2] <= TW'(sc_r) * TW'(cy_r);
      t_r[3] <= TW'(cs_r) * TW'(sy_r);
      t_r[4] <= TW'(cs_r) * TW'(cy_r);
      t_r[5] <= TW'(sc_r) * TW'(sy_r);
      t_r[6] <= TW'(cc_r) * TW'(sy_r);
      t_r[7] <= TW'(ss_r) * TW'(cy_r);
    end
  end

  always_comb begin
    s[0] = t_r[0] + t_r[1];
    s[1] = t_r[2] - t_r[3];
    s[2] = t_r[4] + t_r[5];
    s[3] = t_r[6] - t_r[7];
    for (int k = 0; k < 4; k++) begin
      v[k] = (s[k] + HALF) >>> SH;
      if (v[k] > LIMV) q[k] = QUAT_W'(LIM);
      else if (v[k] < -LIMV) q[k] = -QUAT_W'(LIM);
      else q[k] = QUAT_W'(v[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_r <= '{quat_w: q[0], quat_x: q[1], quat_y: q[2], quat_z: q[3]};
    end
  end

  assign quat = quat_r;
endmodule

// ----- design/euler_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// euler_to_quaternion: Z-Y-X Euler angles to unit quaternion
// Throughput: one item per cycle; the pipeline advances whenever the output
// register is empty or being taken, so a stall freezes all stages.
// Reset: synchronous active-low rst_n clears the stage valid bits only.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
  parameter int CORDIC_STEPS  = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input logic       clk,
  input logic       rst_n,
  e2q_stream_if.sink   in_ch,
  e2q_stream_if.source out_ch
);
  import e2q_pkg::*;

  localparam int N   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int LAT = N + 4;   // reduce, N iterations, pair, triple, round

  angles_t ang;
  cval_t   sr, cr, sp, cp, sy, cy;
  quat_t   quat;
  logic [LAT-1:0] vld_r, vld_nxt;
  logic    en;

  assign ang = angles_t'(in_ch.data);

  // advance the whole pipe unless the final item is waiting
  assign en = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  e2q_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en), .angle(ang.roll_angle), .sin_o(sr), .cos_o(cr));
  e2q_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(en), .angle(ang.pitch_angle), .sin_o(sp), .cos_o(cp));
  e2q_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en), .angle(ang.yaw_angle), .sin_o(sy), .cos_o(cy));

  e2q_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_comb (
    .clk(clk), .en(en), .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
    .quat(quat));

  assign out_ch.valid = vld_r[LAT-1];
  assign out_ch.data  = quat;

  // a waiting result stalls the input
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready) else $error("stall leak");
  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data)) else $error("data moved");
  // an accepted item enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0]) else $error("item lost");
endmodule
